FILE: rtl/tcps_pkg.sv
// Shared types and constants for the two-class priority server.
`default_nettype none

package tcps_pkg;

   localparam int unsigned TICK_W   = 16;
   localparam int unsigned SVC_W    = 4;
   localparam int unsigned COUNT_W  = 32;
   localparam int unsigned OCC_W    = 8;

   localparam logic CLASS_REGULAR  = 1'b0;
   localparam logic CLASS_PRIORITY = 1'b1;

   typedef struct packed {
      logic              arrive;
      logic              arrive_priority;
      logic [SVC_W-1:0]  service_time;
   } req_payload_type;

   typedef struct packed {
      logic               served;
      logic               served_priority;
      logic [TICK_W-1:0]  wait_time;
      logic               dropped;
      logic               server_busy;
      logic [COUNT_W-1:0] regular_served_count;
      logic [COUNT_W-1:0] priority_served_count;
      logic [COUNT_W-1:0] regular_wait_total;
      logic [COUNT_W-1:0] priority_wait_total;
      logic [OCC_W-1:0]   regular_waiting;
      logic [OCC_W-1:0]   priority_waiting;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: rtl/tcps_if.sv
// Valid/ready channel interfaces for the tick requests and the results.
`default_nettype none

interface tcps_req_if;
   logic                       valid;
   logic                       ready;
   tcps_pkg::req_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tcps_rsp_if;
   logic                       valid;
   logic                       ready;
   tcps_pkg::rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/two_class_priority_server.sv
// Single server with a regular and a priority waiting line, strict priority.
//
// Usage: every transaction on req_ch is one time tick. It may carry an arrival
// (arrive, its class in arrive_priority) and the service duration that applies
// if a service starts in this tick. Each tick yields exactly one transaction on
// rsp_ch with the service decision, the wait time of the customer served, the
// drop flag, the busy flag and the running per-class counts, totals and queue
// occupancies.
// The first stage updates the queue pointers, the busy timer and the tick
// count, and reads the stamp at each queue head from its memory; the second
// turns the stamp into a wait time and updates the saturating counts and
// totals into the result register.
// Throughput is one tick per cycle while rsp_ch does not stall, as the pointers
// and timer are updated once per tick and each stamp memory has one read port.
// A synchronous, active-high reset empties both lines, clears the tick count,
// the busy timer, the counts and totals and both pipeline stages. The stamp
// memories are not cleared; occupancy decides what is ever read.
// When the receiver stalls, the result waits in its register, one more tick
// can be taken into the middle stage, and then req_ch.ready goes low.
`default_nettype none

module two_class_priority_server #(
   parameter int unsigned QUEUE_DEPTH = 128,
   parameter int unsigned MAX_SERVICE = 10
) (
   input  wire logic     clock,
   input  wire logic     reset,
   tcps_req_if.sink      req_ch,
   tcps_rsp_if.source    rsp_ch
);

   localparam int unsigned AW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned BW = $clog2(MAX_SERVICE + 1);
   localparam int unsigned TW = tcps_pkg::TICK_W;
   localparam int unsigned NW = tcps_pkg::COUNT_W;
   localparam int unsigned OW = tcps_pkg::OCC_W;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
      logic [AW-1:0] nxt;
      if (ptr == AW'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   function automatic logic [OW-1:0] occupancy(input logic [CW-1:0] cnt);
      logic [CW+OW-1:0] ext;
      ext = {{OW{1'b0}}, cnt};
      return ext[OW-1:0];
   endfunction

   // Queue state and timers.
   logic [AW-1:0] r_head_ff, r_tail_ff, p_head_ff, p_tail_ff;
   logic [CW-1:0] r_count_ff, p_count_ff, r_count_in, p_count_in;
   logic [TW-1:0] tick_ff;
   logic [BW-1:0] busy_ff, busy_in;

   // Stamp memories, one per class.
   logic [TW-1:0] r_mem [QUEUE_DEPTH];
   logic [TW-1:0] p_mem [QUEUE_DEPTH];
   logic [TW-1:0] r_rd_ff, p_rd_ff;

   // Middle stage.
   logic          s1_valid_ff, s1_served_ff, s1_cls_ff, s1_bypass_ff;
   logic          s1_dropped_ff, s1_busy_ff;
   logic [TW-1:0] s1_tick_ff;
   logic [CW-1:0] s1_rcount_ff, s1_pcount_ff;

   // Result register and running statistics.
   logic          rsp_valid_ff, rsp_served_ff, rsp_cls_ff, rsp_dropped_ff, rsp_busy_ff;
   logic [TW-1:0] rsp_wait_ff;
   logic [OW-1:0] rsp_rwait_ff, rsp_pwait_ff;
   logic [NW-1:0] r_served_ff, p_served_ff, r_total_ff, p_total_ff;
   logic [NW-1:0] r_served_in, p_served_in, r_total_in, p_total_in;

   logic          req_fire, s2_free, s1_move;
   logic          arr_r, arr_p, push_r, push_p, dropped;
   logic [CW-1:0] r_cnt_push, p_cnt_push;
   logic [BW-1:0] busy_dec, dur;
   logic          idle, pop_r, pop_p, pop_any, bypass;
   logic [TW-1:0] stamp, wait_val;
   logic [NW:0]   total_sum;
   tcps_pkg::rsp_payload_type rsp_payload;

   // Handshake: the middle stage moves on whenever the result register is free.
   assign s2_free      = !rsp_valid_ff || rsp_ch.ready;
   assign s1_move      = s1_valid_ff && s2_free;
   assign req_ch.ready = !s1_valid_ff || s2_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // First stage: arrival, service selection and timer update for one tick.
   always_comb begin
      arr_r = req_ch.payload.arrive
              && (req_ch.payload.arrive_priority == tcps_pkg::CLASS_REGULAR);
      arr_p = req_ch.payload.arrive
              && (req_ch.payload.arrive_priority == tcps_pkg::CLASS_PRIORITY);
      push_r  = arr_r && (r_count_ff != CW'(QUEUE_DEPTH));
      push_p  = arr_p && (p_count_ff != CW'(QUEUE_DEPTH));
      dropped = (arr_r && !push_r) || (arr_p && !push_p);

      r_cnt_push = r_count_ff + CW'(push_r);
      p_cnt_push = p_count_ff + CW'(push_p);

      busy_dec = (busy_ff != '0) ? busy_ff - 1'b1 : '0;
      idle     = (busy_dec == '0);
      pop_p    = idle && (p_cnt_push != '0);
      pop_r    = idle && !pop_p && (r_cnt_push != '0);
      pop_any  = pop_p || pop_r;

      // A customer that arrives to an empty line and is served in the same
      // tick is still written to memory, but its stamp is taken as the current tick.
      bypass = (pop_p && (p_count_ff == '0)) || (pop_r && (r_count_ff == '0));

      if (req_ch.payload.service_time == '0) begin
         dur = BW'(1);
      end else if (32'(req_ch.payload.service_time) > MAX_SERVICE) begin
         dur = BW'(MAX_SERVICE);
      end else begin
         dur = BW'(req_ch.payload.service_time);
      end

      busy_in    = pop_any ? dur : busy_dec;
      r_count_in = r_cnt_push - CW'(pop_r);
      p_count_in = p_cnt_push - CW'(pop_p);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_head_ff   <= '0;
         r_tail_ff   <= '0;
         r_count_ff  <= '0;
         p_head_ff   <= '0;
         p_tail_ff   <= '0;
         p_count_ff  <= '0;
         tick_ff     <= '0;
         busy_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            if (push_r) begin
               r_tail_ff <= next_ptr(r_tail_ff);
            end
            if (push_p) begin
               p_tail_ff <= next_ptr(p_tail_ff);
            end
            if (pop_r) begin
               r_head_ff <= next_ptr(r_head_ff);
            end
            if (pop_p) begin
               p_head_ff <= next_ptr(p_head_ff);
            end
            r_count_ff <= r_count_in;
            p_count_ff <= p_count_in;
            busy_ff    <= busy_in;
            tick_ff    <= tick_ff + 1'b1;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_served_ff  <= pop_any;
         s1_cls_ff     <= pop_p;
         s1_bypass_ff  <= bypass;
         s1_dropped_ff <= dropped;
         s1_busy_ff    <= (busy_in != '0);
         s1_tick_ff    <= tick_ff;
         s1_rcount_ff  <= r_count_in;
         s1_pcount_ff  <= p_count_in;
      end
   end

   // Stamp memories: written at the tail, head read registered on each tick.
   always_ff @(posedge clock) begin
      if (req_fire && push_r) begin
         r_mem[r_tail_ff] <= tick_ff;
      end
      if (req_fire) begin
         r_rd_ff <= r_mem[r_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && push_p) begin
         p_mem[p_tail_ff] <= tick_ff;
      end
      if (req_fire) begin
         p_rd_ff <= p_mem[p_head_ff];
      end
   end

   // Second stage: wait time and saturating statistics.
   always_comb begin
      stamp    = s1_cls_ff ? p_rd_ff : r_rd_ff;
      wait_val = (s1_served_ff && !s1_bypass_ff) ? s1_tick_ff - stamp : '0;
      total_sum = {1'b0, (s1_cls_ff ? p_total_ff : r_total_ff)}
                  + (NW + 1)'(wait_val);

      r_served_in = r_served_ff;
      p_served_in = p_served_ff;
      r_total_in  = r_total_ff;
      p_total_in  = p_total_ff;
      if (s1_served_ff) begin
         if (s1_cls_ff == tcps_pkg::CLASS_PRIORITY) begin
            if (p_served_ff != '1) begin
               p_served_in = p_served_ff + 1'b1;
            end
            p_total_in = total_sum[NW] ? '1 : total_sum[NW-1:0];
         end else begin
            if (r_served_ff != '1) begin
               r_served_in = r_served_ff + 1'b1;
            end
            r_total_in = total_sum[NW] ? '1 : total_sum[NW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         r_served_ff  <= '0;
         p_served_ff  <= '0;
         r_total_ff   <= '0;
         p_total_ff   <= '0;
      end else begin
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
            r_served_ff  <= r_served_in;
            p_served_ff  <= p_served_in;
            r_total_ff   <= r_total_in;
            p_total_ff   <= p_total_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_served_ff  <= s1_served_ff;
         rsp_cls_ff     <= s1_served_ff && s1_cls_ff;
         rsp_wait_ff    <= wait_val;
         rsp_dropped_ff <= s1_dropped_ff;
         rsp_busy_ff    <= s1_busy_ff;
         rsp_rwait_ff   <= occupancy(s1_rcount_ff);
         rsp_pwait_ff   <= occupancy(s1_pcount_ff);
      end
   end

   always_comb begin
      rsp_payload.served                = rsp_served_ff;
      rsp_payload.served_priority       = rsp_cls_ff;
      rsp_payload.wait_time             = rsp_wait_ff;
      rsp_payload.dropped               = rsp_dropped_ff;
      rsp_payload.server_busy           = rsp_busy_ff;
      rsp_payload.regular_served_count  = r_served_ff;
      rsp_payload.priority_served_count = p_served_ff;
      rsp_payload.regular_wait_total    = r_total_ff;
      rsp_payload.priority_wait_total   = p_total_ff;
      rsp_payload.regular_waiting       = rsp_rwait_ff;
      rsp_payload.priority_waiting      = rsp_pwait_ff;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload;

`ifndef SYNTHESIS
   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      (r_count_ff <= CW'(QUEUE_DEPTH)) && (p_count_ff <= CW'(QUEUE_DEPTH)))
      else $error("queue occupancy exceeds its depth");

   a_busy_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff <= BW'(MAX_SERVICE))
      else $error("busy timer exceeds the longest service");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("tick accepted while both stages are full and stalled");

   a_bypass_is_service: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_bypass_ff) |-> s1_served_ff)
      else $error("stamp bypass without a service");

   a_served_counted: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_served_ff) |=> ((p_served_ff != '0) || (r_served_ff != '0)))
      else $error("service delivered without raising a count");
`endif

endmodule

`default_nettype wire
